FILE: hdl/msc_pkg.sv
// Shared types and constants for the motor speed PI ramp controller.
package msc_pkg;

    localparam int unsigned SPEED_W = 14;
    localparam int unsigned STEP_W  = 8;
    localparam int unsigned GAIN_W  = 24;
    localparam int unsigned RAMP_W  = 16;
    localparam int unsigned SUM_W   = 32;
    localparam int unsigned DUTY_W  = 8;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_ACCEL = 2'd1,
        MODE_HOLD  = 2'd2,
        MODE_DECEL = 2'd3
    } t_mode;

    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACCEL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DECEL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_GAIN    = 3'd4;

    localparam logic [SPEED_W-1:0] TARGET_SPEED_RST = 14'd1501;
    localparam logic [STEP_W-1:0]  RAMP_STEP_RST    = 8'd4;
    localparam logic [SPEED_W-1:0] WINDOW_LOW_RST   = 14'd1495;
    localparam logic [SPEED_W-1:0] WINDOW_HIGH_RST  = 14'd1505;
    localparam logic [GAIN_W-1:0]  DUTY_GAIN_RST    = 24'd8022;

endpackage

FILE: hdl/msc_if.sv
// Channel interfaces: control tick input, duty result, configuration write.
interface msc_in_if import msc_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [SPEED_W-1:0] measured_speed;

    modport source (output valid, output cmd, output measured_speed, input ready);
    modport sink   (input valid, input cmd, input measured_speed, output ready);
endinterface

interface msc_out_if import msc_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty;
    logic [1:0]        mode;

    modport source (output valid, output duty, output mode, input ready);
    modport sink   (input valid, input duty, input mode, output ready);
endinterface

interface msc_cfg_if import msc_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/motor_speed_pi_ramp_controller_top.sv
// Motor speed PI controller with start/stop ramp, top level.
//
//  channel   | dir | payload                         | handshake
//  i_item    | in  | cmd[1:0], measured_speed[13:0]  | valid/ready
//  o_result  | out | duty[7:0], mode[1:0]            | valid/ready
//  i_cfg     | in  | index[2:0], data[23:0]          | valid/ready, ready always high
//
// One tick per cycle while the result is not stalled; each tick runs input register ->
// state update -> multiply -> result register.
// The mode, ramp and error sum loop closes within the state-update stage.
// The 32x24 duty multiply sits between its own register stage and the result.
// Synchronous active-low reset clears valid flags and state and reloads the
// default configuration.
// A stalled result holds; stages behind it keep filling until all are full.
module motor_speed_pi_ramp_controller_top import msc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    msc_in_if.sink     i_item,
    msc_cfg_if.sink    i_cfg,
    msc_out_if.source  o_result
);

    // configuration
    logic [SPEED_W-1:0] r_target;
    logic [STEP_W-1:0]  r_step;
    logic [SPEED_W-1:0] r_win_lo;
    logic [SPEED_W-1:0] r_win_hi;
    logic [GAIN_W-1:0]  r_gain;

    // controller state
    t_mode                    r_mode;
    logic signed [RAMP_W-1:0] r_ramp;
    logic signed [SUM_W-1:0]  r_sum;

    // pipeline
    logic               r_s1_vld;
    logic [CMD_W-1:0]   r_s1_cmd;
    logic [SPEED_W-1:0] r_s1_speed;
    logic               r_s2_vld;
    logic               r_s2_pos;
    logic [SUM_W-1:0]   r_s2_mag;
    t_mode              r_s2_mode;
    logic               r_out_vld;
    logic [DUTY_W-1:0]  r_out_duty;
    t_mode              r_out_mode;

    logic out_free, s2_free, s1_free, s1_move;

    t_mode                    mode_pre;
    t_mode                    n_mode;
    logic signed [RAMP_W-1:0] n_ramp;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [RAMP_W:0]   w_ref;
    logic signed [RAMP_W+1:0] w_err;
    logic signed [SUM_W+1:0]  w_sum_raw;
    logic signed [SUM_W+1:0]  w_x;
    logic signed [RAMP_W:0]   w_ramp_up;
    logic signed [RAMP_W:0]   w_ramp_dn;
    logic                     w_active;
    logic                     n_pos;
    logic [SUM_W+GAIN_W-1:0]  w_prod;
    logic [DUTY_W-1:0]        n_duty;

    assign out_free = !r_out_vld || o_result.ready;
    assign s2_free  = !r_s2_vld || out_free;
    assign s1_free  = !r_s1_vld || s2_free;
    assign s1_move  = r_s1_vld && s2_free;

    assign i_item.ready    = s1_free;
    assign i_cfg.ready     = 1'b1;
    assign o_result.valid  = r_out_vld;
    assign o_result.duty   = r_out_duty;
    assign o_result.mode   = r_out_mode;

    // state update stage
    always_comb begin
        case (r_s1_cmd)
            CMD_ACCEL: mode_pre = MODE_ACCEL;
            CMD_DECEL: mode_pre = MODE_DECEL;
            default:   mode_pre = r_mode;
        endcase

        w_active = (mode_pre != MODE_IDLE);

        if (mode_pre == MODE_HOLD) begin
            w_ref = signed'({3'b000, r_target});
        end else begin
            w_ref = {r_ramp[RAMP_W-1], r_ramp};
        end
        w_err = {w_ref[RAMP_W], w_ref} - signed'({4'b0000, r_s1_speed});

        w_sum_raw = {{2{r_sum[SUM_W-1]}}, r_sum} + {{16{w_err[RAMP_W+1]}}, w_err};
        // saturate to the signed 32-bit range
        if (w_sum_raw[SUM_W+1:SUM_W-1] != 3'b000 && w_sum_raw[SUM_W+1:SUM_W-1] != 3'b111)
        begin
            n_sum = w_sum_raw[SUM_W+1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                       : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            n_sum = w_sum_raw[SUM_W-1:0];
        end
        w_x = {{2{n_sum[SUM_W-1]}}, n_sum} + {{16{w_err[RAMP_W+1]}}, w_err};
        // a positive sum of error and integral always fits 32 unsigned bits
        n_pos = w_active && !w_x[SUM_W+1] && (w_x != '0);

        w_ramp_up = {r_ramp[RAMP_W-1], r_ramp} + signed'({9'd0, r_step});
        w_ramp_dn = {r_ramp[RAMP_W-1], r_ramp} - signed'({9'd0, r_step});

        n_mode = mode_pre;
        n_ramp = r_ramp;
        case (mode_pre)
            MODE_ACCEL: begin
                n_ramp = (w_ramp_up[RAMP_W] != w_ramp_up[RAMP_W-1]) ?
                         {1'b0, {(RAMP_W-1){1'b1}}} : w_ramp_up[RAMP_W-1:0];
                if (r_s1_speed > r_win_lo && r_s1_speed < r_win_hi) begin
                    n_mode = MODE_HOLD;
                end
            end
            MODE_HOLD: begin
                n_ramp = signed'({2'b00, r_s1_speed});
            end
            MODE_DECEL: begin
                n_ramp = (w_ramp_dn[RAMP_W] != w_ramp_dn[RAMP_W-1]) ?
                         {1'b1, {(RAMP_W-1){1'b0}}} : w_ramp_dn[RAMP_W-1:0];
                if (r_s1_speed == '0) begin
                    n_mode = MODE_IDLE;
                end
            end
            default: begin
                n_ramp = r_ramp;
            end
        endcase
        if (!w_active) begin
            n_sum = r_sum;
        end
    end

    // multiply stage: Q24 gain, quotient clamped to 8 bits, zero unless positive
    always_comb begin
        w_prod = r_s2_mag * r_gain;
        if (!r_s2_pos) begin
            n_duty = '0;
        end else if (|w_prod[SUM_W+GAIN_W-1:GAIN_W+DUTY_W]) begin
            n_duty = '1;
        end else begin
            n_duty = w_prod[GAIN_W+DUTY_W-1:GAIN_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= TARGET_SPEED_RST;
            r_step    <= RAMP_STEP_RST;
            r_win_lo  <= WINDOW_LOW_RST;
            r_win_hi  <= WINDOW_HIGH_RST;
            r_gain    <= DUTY_GAIN_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_TARGET_SPEED: r_target <= i_cfg.data[SPEED_W-1:0];
                REG_RAMP_STEP:    r_step   <= i_cfg.data[STEP_W-1:0];
                REG_WINDOW_LOW:   r_win_lo <= i_cfg.data[SPEED_W-1:0];
                REG_WINDOW_HIGH:  r_win_hi <= i_cfg.data[SPEED_W-1:0];
                REG_DUTY_GAIN:    r_gain   <= i_cfg.data[GAIN_W-1:0];
                default:          r_gain   <= r_gain;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_ramp    <= '0;
            r_sum     <= '0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_vld <= i_item.valid;
            end
            if (s1_move) begin
                r_mode <= n_mode;
                r_ramp <= n_ramp;
                r_sum  <= n_sum;
            end
            if (s2_free) begin
                r_s2_vld <= r_s1_vld;
            end
            if (out_free) begin
                r_out_vld <= r_s2_vld;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s1_free && i_item.valid) begin
            r_s1_cmd   <= i_item.cmd;
            r_s1_speed <= i_item.measured_speed;
        end
        if (s1_move) begin
            r_s2_pos  <= n_pos;
            r_s2_mag  <= w_x[SUM_W-1:0];
            r_s2_mode <= n_mode;
        end
        if (out_free && r_s2_vld) begin
            r_out_duty <= n_duty;
            r_out_mode <= r_s2_mode;
        end
    end

endmodule

FILE: hdl/msc_checker.sv
// Port-level assertions for the controller top level, with its bind.
module msc_checker import msc_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [DUTY_W-1:0] i_out_duty,
    input logic [1:0]        i_out_mode
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_duty) && $stable(i_out_mode))
        else $error("result changed while stalled");

    // an offered result carries a fully known payload
    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !$isunknown({i_out_duty, i_out_mode}))
        else $error("unknown bits in result payload");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind motor_speed_pi_ramp_controller_top msc_checker u_msc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_duty  (o_result.duty),
    .i_out_mode  (o_result.mode)
);
